FILE: sv/x86enc_pkg.sv
// ----------------------------------------------------------------------------
// x86enc_pkg
// Shared types and constants for the x86-64 instruction byte encoder.
// ----------------------------------------------------------------------------
package x86enc_pkg;

    localparam int LABEL_SLOTS = 64;
    localparam int MAX_BYTES   = 10;
    localparam int LEN_W       = 4;
    localparam int QDEPTH      = 2;

    localparam logic [7:0] REX_BASE = 8'h40;
    localparam logic [7:0] SIB_RSP  = 8'h24;
    localparam logic [7:0] LOCK_PFX = 8'hF0;
    localparam logic [7:0] REP_PFX  = 8'hF3;
    localparam logic [7:0] ESC_0F   = 8'h0F;

    typedef enum logic [5:0] {
        ACT_MOV_RR, ACT_MOV_RI64, ACT_MOV_RI32, ACT_MOV_RM, ACT_MOV_MR,
        ACT_ADD_RR, ACT_ADD_RI, ACT_ADD_MR, ACT_SUB_RR, ACT_SUB_RI,
        ACT_IMUL_RR, ACT_IMUL_RRI, ACT_AND_RR, ACT_AND_RI, ACT_OR_RR,
        ACT_OR_RI, ACT_XOR_RR, ACT_XOR_RI, ACT_SHL_CL, ACT_SHL_RI,
        ACT_SAR_CL, ACT_SAR_RI, ACT_SHR_CL, ACT_SHR_RI, ACT_BTS_RR,
        ACT_BTS_RI, ACT_BTR_RR, ACT_BTR_RI, ACT_POPCNT, ACT_LZCNT,
        ACT_CMP_RR, ACT_CMP_RI, ACT_TEST_RR, ACT_JMP, ACT_JE,
        ACT_JNE, ACT_JL, ACT_JGE, ACT_CALL, ACT_PUSH,
        ACT_POP, ACT_RET, ACT_LOCK_CMPXCHG, ACT_XCHG_MR, ACT_LOCK_ADD,
        ACT_LOCK_AND, ACT_LOCK_OR, ACT_MFENCE, ACT_CLFLUSH, ACT_RESTART
    } act_t;

    typedef struct packed {
        logic                          restart;
        logic [MAX_BYTES-1:0][7:0]     bytes;
        logic [LEN_W-1:0]              len;
        logic                          patch;
        logic [LEN_W-1:0]              patch_idx;
        logic [5:0]                    label;
    } enc_t;

    function automatic logic fits8(input logic [31:0] v);
        return (v[31:7] == '0) || (v[31:7] == '1);
    endfunction

endpackage

FILE: sv/x86enc_front.sv
// ----------------------------------------------------------------------------
// x86enc_front
// Classifies one request and lays out its instruction bytes.
// ----------------------------------------------------------------------------
module x86enc_front (
    input  logic [5:0]           action,
    input  logic [3:0]           first_reg,
    input  logic [3:0]           second_reg,
    input  logic signed [31:0]   displacement,
    input  logic [63:0]          immediate,
    input  logic [5:0]           jump_label,
    output logic                 enc_valid,
    output x86enc_pkg::enc_t     enc
);

    logic        form_ok, w, pre_en, mrm_en, mem, jump;
    logic [7:0]  pre_b, op0, op1;
    logic [1:0]  op_n, mod_rr;
    logic [3:0]  rr, rm, imm_n;
    logic [31:0] disp, imm32;
    logic        dz, d8, sib_en, rex_en;
    logic [1:0]  mod_f;
    logic [3:0]  tail_n, n;
    logic [63:0] tail;
    logic [7:0]  rex_b, mrm_b;
    logic [x86enc_pkg::MAX_BYTES-1:0][7:0] bb;

    assign disp  = displacement;
    assign imm32 = immediate[31:0];

    always_comb begin
        form_ok = 1'b1; w = 1'b1; pre_en = 1'b0; pre_b = x86enc_pkg::LOCK_PFX;
        op_n = 2'd1; op0 = 8'h00; op1 = 8'h00; mrm_en = 1'b1; mem = 1'b0;
        mod_rr = 2'd3; rr = second_reg; rm = first_reg; imm_n = 4'd0; jump = 1'b0;
        case (x86enc_pkg::act_t'(action))
            x86enc_pkg::ACT_MOV_RR: begin
                form_ok = (first_reg != second_reg); op0 = 8'h89;
            end
            x86enc_pkg::ACT_MOV_RI64: begin
                rr = 4'd0; mrm_en = 1'b0; op0 = 8'hB8 + {5'd0, first_reg[2:0]};
                imm_n = 4'd8;
            end
            x86enc_pkg::ACT_MOV_RI32: begin
                rr = 4'd0; op0 = 8'hC7; imm_n = 4'd4;
            end
            x86enc_pkg::ACT_MOV_RM: begin
                mem = 1'b1; op0 = 8'h8B; rr = first_reg; rm = second_reg;
            end
            x86enc_pkg::ACT_MOV_MR:   begin mem = 1'b1; op0 = 8'h89; end
            x86enc_pkg::ACT_ADD_MR:   begin mem = 1'b1; op0 = 8'h01; end
            x86enc_pkg::ACT_XCHG_MR:  begin mem = 1'b1; op0 = 8'h87; end
            x86enc_pkg::ACT_LOCK_ADD: begin mem = 1'b1; op0 = 8'h01; pre_en = 1'b1; end
            x86enc_pkg::ACT_LOCK_AND: begin mem = 1'b1; op0 = 8'h21; pre_en = 1'b1; end
            x86enc_pkg::ACT_LOCK_OR:  begin mem = 1'b1; op0 = 8'h09; pre_en = 1'b1; end
            x86enc_pkg::ACT_LOCK_CMPXCHG: begin
                mem = 1'b1; pre_en = 1'b1; op_n = 2'd2;
                op0 = x86enc_pkg::ESC_0F; op1 = 8'hB1;
            end
            x86enc_pkg::ACT_ADD_RR:  op0 = 8'h01;
            x86enc_pkg::ACT_SUB_RR:  op0 = 8'h29;
            x86enc_pkg::ACT_AND_RR:  op0 = 8'h21;
            x86enc_pkg::ACT_OR_RR:   op0 = 8'h09;
            x86enc_pkg::ACT_XOR_RR:  op0 = 8'h31;
            x86enc_pkg::ACT_CMP_RR:  op0 = 8'h39;
            x86enc_pkg::ACT_TEST_RR: op0 = 8'h85;
            x86enc_pkg::ACT_ADD_RI, x86enc_pkg::ACT_SUB_RI, x86enc_pkg::ACT_AND_RI,
            x86enc_pkg::ACT_OR_RI, x86enc_pkg::ACT_XOR_RI, x86enc_pkg::ACT_CMP_RI: begin
                case (x86enc_pkg::act_t'(action))
                    x86enc_pkg::ACT_ADD_RI: rr = 4'd0;
                    x86enc_pkg::ACT_SUB_RI: rr = 4'd5;
                    x86enc_pkg::ACT_AND_RI: rr = 4'd4;
                    x86enc_pkg::ACT_OR_RI:  rr = 4'd1;
                    x86enc_pkg::ACT_XOR_RI: rr = 4'd6;
                    default:                rr = 4'd7;
                endcase
                op0   = x86enc_pkg::fits8(imm32) ? 8'h83 : 8'h81;
                imm_n = x86enc_pkg::fits8(imm32) ? 4'd1 : 4'd4;
            end
            x86enc_pkg::ACT_IMUL_RR: begin
                op_n = 2'd2; op0 = x86enc_pkg::ESC_0F; op1 = 8'hAF;
                rr = first_reg; rm = second_reg;
            end
            x86enc_pkg::ACT_IMUL_RRI: begin
                rr = first_reg; rm = second_reg;
                op0   = x86enc_pkg::fits8(imm32) ? 8'h6B : 8'h69;
                imm_n = x86enc_pkg::fits8(imm32) ? 4'd1 : 4'd4;
            end
            x86enc_pkg::ACT_SHL_CL: begin op0 = 8'hD3; rr = 4'd4; end
            x86enc_pkg::ACT_SAR_CL: begin op0 = 8'hD3; rr = 4'd7; end
            x86enc_pkg::ACT_SHR_CL: begin op0 = 8'hD3; rr = 4'd5; end
            x86enc_pkg::ACT_SHL_RI, x86enc_pkg::ACT_SAR_RI, x86enc_pkg::ACT_SHR_RI: begin
                case (x86enc_pkg::act_t'(action))
                    x86enc_pkg::ACT_SHL_RI: rr = 4'd4;
                    x86enc_pkg::ACT_SAR_RI: rr = 4'd7;
                    default:                rr = 4'd5;
                endcase
                op0   = (immediate[7:0] == 8'd1) ? 8'hD1 : 8'hC1;
                imm_n = (immediate[7:0] == 8'd1) ? 4'd0 : 4'd1;
            end
            x86enc_pkg::ACT_BTS_RR: begin
                op_n = 2'd2; op0 = x86enc_pkg::ESC_0F; op1 = 8'hAB;
            end
            x86enc_pkg::ACT_BTR_RR: begin
                op_n = 2'd2; op0 = x86enc_pkg::ESC_0F; op1 = 8'hB3;
            end
            x86enc_pkg::ACT_BTS_RI, x86enc_pkg::ACT_BTR_RI: begin
                op_n = 2'd2; op0 = x86enc_pkg::ESC_0F; op1 = 8'hBA; imm_n = 4'd1;
                rr = (x86enc_pkg::act_t'(action) == x86enc_pkg::ACT_BTS_RI) ? 4'd5 : 4'd6;
            end
            x86enc_pkg::ACT_POPCNT, x86enc_pkg::ACT_LZCNT: begin
                pre_en = 1'b1; pre_b = x86enc_pkg::REP_PFX; op_n = 2'd2;
                op0 = x86enc_pkg::ESC_0F; rr = first_reg; rm = second_reg;
                op1 = (x86enc_pkg::act_t'(action) == x86enc_pkg::ACT_POPCNT) ? 8'hB8 : 8'hBD;
            end
            x86enc_pkg::ACT_JMP: begin
                w = 1'b0; rr = 4'd0; rm = 4'd0; mrm_en = 1'b0; op0 = 8'hE9;
                imm_n = 4'd4; jump = 1'b1;
            end
            x86enc_pkg::ACT_JE, x86enc_pkg::ACT_JNE, x86enc_pkg::ACT_JL,
            x86enc_pkg::ACT_JGE: begin
                w = 1'b0; rr = 4'd0; rm = 4'd0; mrm_en = 1'b0; op_n = 2'd2;
                op0 = x86enc_pkg::ESC_0F; imm_n = 4'd4; jump = 1'b1;
                case (x86enc_pkg::act_t'(action))
                    x86enc_pkg::ACT_JE:  op1 = 8'h84;
                    x86enc_pkg::ACT_JNE: op1 = 8'h85;
                    x86enc_pkg::ACT_JL:  op1 = 8'h8C;
                    default:             op1 = 8'h8D;
                endcase
            end
            x86enc_pkg::ACT_CALL: begin w = 1'b0; rr = 4'd2; op0 = 8'hFF; end
            x86enc_pkg::ACT_PUSH: begin
                w = 1'b0; rr = 4'd0; mrm_en = 1'b0; op0 = 8'h50 + {5'd0, first_reg[2:0]};
            end
            x86enc_pkg::ACT_POP: begin
                w = 1'b0; rr = 4'd0; mrm_en = 1'b0; op0 = 8'h58 + {5'd0, first_reg[2:0]};
            end
            x86enc_pkg::ACT_RET: begin
                w = 1'b0; rr = 4'd0; rm = 4'd0; mrm_en = 1'b0; op0 = 8'hC3;
            end
            x86enc_pkg::ACT_MFENCE: begin
                w = 1'b0; rr = 4'd6; rm = 4'd0; op_n = 2'd2;
                op0 = x86enc_pkg::ESC_0F; op1 = 8'hAE;
            end
            x86enc_pkg::ACT_CLFLUSH: begin
                w = 1'b0; rr = 4'd7; mem = 1'b1; op_n = 2'd2;
                op0 = x86enc_pkg::ESC_0F; op1 = 8'hAE;
            end
            default: form_ok = 1'b0;
        endcase
    end

    // memory operand: no disp, disp8 or disp32; rbp/r13 base always has disp
    assign dz     = (disp == 32'd0) && (rm[2:0] != 3'd5);
    assign d8     = x86enc_pkg::fits8(disp);
    assign mod_f  = dz ? 2'd0 : (d8 ? 2'd1 : 2'd2);
    assign sib_en = mem && (rm[2:0] == 3'd4);
    assign tail_n = mem ? (dz ? 4'd0 : (d8 ? 4'd1 : 4'd4)) : imm_n;
    assign tail   = mem ? {32'd0, disp} : (jump ? 64'd0 : immediate);
    assign rex_en = w || rr[3] || rm[3];
    assign rex_b  = x86enc_pkg::REX_BASE | {4'd0, w, rr[3], 1'b0, rm[3]};
    assign mrm_b  = {(mem ? mod_f : mod_rr), rr[2:0], rm[2:0]};

    always_comb begin
        bb = '0;
        n  = 4'd0;
        if (pre_en) begin bb[n] = pre_b; n = n + 4'd1; end
        if (rex_en) begin bb[n] = rex_b; n = n + 4'd1; end
        bb[n] = op0; n = n + 4'd1;
        if (op_n == 2'd2) begin bb[n] = op1; n = n + 4'd1; end
        if (mrm_en) begin bb[n] = mrm_b; n = n + 4'd1; end
        if (sib_en) begin bb[n] = x86enc_pkg::SIB_RSP; n = n + 4'd1; end
        enc.patch_idx = n;
        for (int t = 0; t < 8; t++) begin
            if ((4'(t) < tail_n) && (n < 4'(x86enc_pkg::MAX_BYTES))) begin
                bb[n] = tail[8*t +: 8];
                n = n + 4'd1;
            end
        end
        enc.bytes   = bb;
        enc.len     = n;
        enc.restart = (x86enc_pkg::act_t'(action) == x86enc_pkg::ACT_RESTART);
        enc.patch   = jump && ({3'd0, jump_label} < 9'(x86enc_pkg::LABEL_SLOTS));
        enc.label   = jump_label;
        enc_valid   = form_ok || enc.restart;
    end

endmodule

FILE: sv/x86enc_queue.sv
// ----------------------------------------------------------------------------
// x86enc_queue
// Two-entry queue of encoded requests between front and back.
// ----------------------------------------------------------------------------
module x86enc_queue (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  x86enc_pkg::enc_t  push_data,
    output logic              full,
    input  logic              pop,
    output logic              head_valid,
    output x86enc_pkg::enc_t  head
);

    x86enc_pkg::enc_t mem_reg [x86enc_pkg::QDEPTH];
    logic       wr_ptr_reg, wr_ptr_next, rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    assign full       = (count_reg == 2'(x86enc_pkg::QDEPTH));
    assign head_valid = (count_reg != 2'd0);
    assign head       = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg + 1'(push);
        rd_ptr_next = rd_ptr_reg + 1'(pop);
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

FILE: sv/x86enc_back.sv
// ----------------------------------------------------------------------------
// x86enc_back
// Streams the bytes of each queued request, tracking the code offset.
// ----------------------------------------------------------------------------
module x86enc_back (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              head_valid,
    input  x86enc_pkg::enc_t  head,
    output logic              pop,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [7:0]        m_code_byte,
    output logic [31:0]       m_byte_position,
    output logic              m_last_byte,
    output logic              m_patch_start,
    output logic [5:0]        m_patch_label
);

    logic [3:0]  idx_reg, idx_next;
    logic [31:0] offset_reg, offset_next;
    logic        valid_reg, valid_next;
    logic [7:0]  byte_reg;
    logic [31:0] pos_reg;
    logic        last_reg, patch_reg;
    logic [5:0]  label_reg;
    logic        load, emit, is_last, is_patch;

    assign load     = !valid_reg || m_ready;
    assign emit     = load && head_valid && !head.restart;
    assign is_last  = (idx_reg == head.len - 4'd1);
    assign is_patch = head.patch && (idx_reg == head.patch_idx);
    assign pop      = load && head_valid && (head.restart || is_last);

    always_comb begin
        idx_next    = idx_reg;
        offset_next = offset_reg;
        valid_next  = load ? emit : valid_reg;
        if (load && head_valid) begin
            if (head.restart) begin
                offset_next = 32'd0;
            end else begin
                offset_next = offset_reg + 32'd1;
                idx_next    = is_last ? 4'd0 : idx_reg + 4'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg    <= 4'd0;
            offset_reg <= 32'd0;
            valid_reg  <= 1'b0;
        end else begin
            idx_reg    <= idx_next;
            offset_reg <= offset_next;
            valid_reg  <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            byte_reg  <= head.bytes[idx_reg];
            pos_reg   <= offset_reg;
            last_reg  <= is_last;
            patch_reg <= is_patch;
            label_reg <= is_patch ? head.label : 6'd0;
        end
    end

    assign m_valid         = valid_reg;
    assign m_code_byte     = byte_reg;
    assign m_byte_position = pos_reg;
    assign m_last_byte     = last_reg;
    assign m_patch_start   = patch_reg;
    assign m_patch_label   = label_reg;

endmodule

FILE: sv/x86_64_instruction_byte_encoder.sv
// ----------------------------------------------------------------------------
// x86_64_instruction_byte_encoder
// Encodes instruction requests into an x86-64 byte stream, one byte a cycle while m_ready is high.
// ----------------------------------------------------------------------------
// A request is registered in the queue, and each of its bytes then in the output register.
// One byte per cycle while m_ready is not held low; the back end's byte counter steps
// through the bytes of each request at the output register.
// Requests that emit nothing are not queued; a restart is queued, clears the offset and emits no byte.
// Reset: synchronous, active low; clears queue, output valid and offset.
module x86_64_instruction_byte_encoder (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [5:0]         s_action,
    input  logic [3:0]         s_first_reg,
    input  logic [3:0]         s_second_reg,
    input  logic signed [31:0] s_displacement,
    input  logic [63:0]        s_immediate,
    input  logic [5:0]         s_jump_label,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [7:0]         m_code_byte,
    output logic [31:0]        m_byte_position,
    output logic               m_last_byte,
    output logic               m_patch_start,
    output logic [5:0]         m_patch_label
);

    x86enc_pkg::enc_t enc, head;
    logic enc_valid, full, push, pop, head_valid;

    x86enc_front u_front (
        .action       (s_action),
        .first_reg    (s_first_reg),
        .second_reg   (s_second_reg),
        .displacement (s_displacement),
        .immediate    (s_immediate),
        .jump_label   (s_jump_label),
        .enc_valid    (enc_valid),
        .enc          (enc)
    );

    assign s_ready = !full;
    assign push    = s_valid && s_ready && enc_valid;

    x86enc_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_data  (enc),
        .full       (full),
        .pop        (pop),
        .head_valid (head_valid),
        .head       (head)
    );

    x86enc_back u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .head_valid      (head_valid),
        .head            (head),
        .pop             (pop),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_code_byte     (m_code_byte),
        .m_byte_position (m_byte_position),
        .m_last_byte     (m_last_byte),
        .m_patch_start   (m_patch_start),
        .m_patch_label   (m_patch_label)
    );

    a_pop_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> head_valid)
        else $error("queue popped while empty");

    a_push_room: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !full)
        else $error("queue pushed while full");

    a_pos_seq: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && !m_last_byte) |=>
            (m_valid && (m_byte_position == $past(m_byte_position) + 32'd1)))
        else $error("byte positions not consecutive within a request");

    a_patch_label: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_patch_start) |-> (m_patch_label == 6'd0))
        else $error("label shown without patch start");

endmodule

FILE: tb/encoder_checker.sv
// ----------------------------------------------------------------------------
// encoder_checker
// Watches the request and byte channels of the x86-64 byte encoder, predicts
// the byte stream of every accepted request and compares each emitted byte.
// ----------------------------------------------------------------------------
module encoder_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [5:0]  s_action,
    input  logic [3:0]  s_first_reg,
    input  logic [3:0]  s_second_reg,
    input  logic [31:0] s_displacement,
    input  logic [63:0] s_immediate,
    input  logic [5:0]  s_jump_label,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [7:0]  m_code_byte,
    input  logic [31:0] m_byte_position,
    input  logic        m_last_byte,
    input  logic        m_patch_start,
    input  logic [5:0]  m_patch_label,
    output int          fail_count,
    output int          pending,
    output int          bytes_seen
);

    typedef struct packed {
        logic [7:0]  code;
        logic [31:0] pos;
        logic        last;
        logic        pstart;
        logic [5:0]  plabel;
    } code_byte_t;

    code_byte_t  byte_queue[$];
    logic [31:0] stream_offset;
    logic [7:0]  buf_b[$];
    int          patch_at;

    assign pending = byte_queue.size();

    function automatic logic in8(logic [31:0] v);
        return (v + 32'd128) < 32'd256;
    endfunction

    function automatic void emit(logic [7:0] b);
        buf_b.push_back(b);
    endfunction

    function automatic void emit32(logic [31:0] v);
        for (int i = 0; i < 4; i++) emit(v[8*i +: 8]);
    endfunction

    function automatic void rex_b(logic w, logic [3:0] r, logic [3:0] m);
        if (w || r[3] || m[3]) emit({4'h4, w, r[3], 1'b0, m[3]});
    endfunction

    function automatic void modrm_b(logic [1:0] md, logic [3:0] r, logic [3:0] m);
        emit({md, r[2:0], m[2:0]});
    endfunction

    function automatic void mem_b(logic [3:0] r, logic [3:0] base, logic [31:0] d);
        logic sib;
        sib = base[2:0] == 3'd4;
        if (d == 0 && base[2:0] != 3'd5) begin
            modrm_b(2'd0, r, base);
            if (sib) emit(x86enc_pkg::SIB_RSP);
        end else if (in8(d)) begin
            modrm_b(2'd1, r, base);
            if (sib) emit(x86enc_pkg::SIB_RSP);
            emit(d[7:0]);
        end else begin
            modrm_b(2'd2, r, base);
            if (sib) emit(x86enc_pkg::SIB_RSP);
            emit32(d);
        end
    endfunction

    function automatic void rr_b(logic [7:0] op, logic [3:0] r, logic [3:0] m);
        rex_b(1'b1, r, m);
        emit(op);
        modrm_b(2'd3, r, m);
    endfunction

    function automatic void alu_b(logic [2:0] ext, logic [3:0] d, logic [31:0] imm);
        rex_b(1'b1, 4'd0, d);
        if (in8(imm)) begin
            emit(8'h83); modrm_b(2'd3, {1'b0, ext}, d); emit(imm[7:0]);
        end else begin
            emit(8'h81); modrm_b(2'd3, {1'b0, ext}, d); emit32(imm);
        end
    endfunction

    function automatic void shcl_b(logic [2:0] ext, logic [3:0] d);
        rex_b(1'b1, 4'd0, d);
        emit(8'hD3);
        modrm_b(2'd3, {1'b0, ext}, d);
    endfunction

    function automatic void shi_b(logic [2:0] ext, logic [3:0] d, logic [7:0] i8);
        rex_b(1'b1, 4'd0, d);
        if (i8 == 8'd1) begin
            emit(8'hD1); modrm_b(2'd3, {1'b0, ext}, d);
        end else begin
            emit(8'hC1); modrm_b(2'd3, {1'b0, ext}, d); emit(i8);
        end
    endfunction

    function automatic void two_b(logic [7:0] op, logic [3:0] r, logic [3:0] m);
        rex_b(1'b1, r, m);
        emit(x86enc_pkg::ESC_0F); emit(op);
        modrm_b(2'd3, r, m);
    endfunction

    function automatic void bit_b(logic [2:0] ext, logic [3:0] d, logic [7:0] i8);
        rex_b(1'b1, 4'd0, d);
        emit(x86enc_pkg::ESC_0F); emit(8'hBA);
        modrm_b(2'd3, {1'b0, ext}, d);
        emit(i8);
    endfunction

    function automatic void jump_b(logic [7:0] cc);
        if (cc == 0) emit(8'hE9);
        else begin
            emit(x86enc_pkg::ESC_0F); emit(cc);
        end
        patch_at = buf_b.size();
        emit32(32'd0);
    endfunction

    function automatic void memf_b(logic lk, logic [7:0] op, logic esc,
                                   logic [3:0] r, logic [3:0] base, logic [31:0] d);
        if (lk) emit(x86enc_pkg::LOCK_PFX);
        rex_b(1'b1, r, base);
        if (esc) emit(x86enc_pkg::ESC_0F);
        emit(op);
        mem_b(r, base, d);
    endfunction

    function automatic void predict_bytes(logic [5:0] a, logic [3:0] f, logic [3:0] s,
                                          logic [31:0] d, logic [63:0] imm, logic [5:0] lb);
        code_byte_t e;
        logic [31:0] i32;
        logic [7:0]  i8;
        i32 = imm[31:0];
        i8 = imm[7:0];
        buf_b.delete();
        patch_at = -1;
        if (a == x86enc_pkg::ACT_RESTART) begin
            stream_offset = 0;
            return;
        end
        if (a > x86enc_pkg::ACT_RESTART) return;
        case (x86enc_pkg::act_t'(a))
            x86enc_pkg::ACT_MOV_RR:   if (f != s) rr_b(8'h89, s, f);
            x86enc_pkg::ACT_MOV_RI64: begin
                rex_b(1'b1, 4'd0, f); emit(8'hB8 + {5'd0, f[2:0]});
                emit32(imm[31:0]); emit32(imm[63:32]);
            end
            x86enc_pkg::ACT_MOV_RI32: begin
                rex_b(1'b1, 4'd0, f); emit(8'hC7); modrm_b(2'd3, 4'd0, f); emit32(i32);
            end
            x86enc_pkg::ACT_MOV_RM:   memf_b(1'b0, 8'h8B, 1'b0, f, s, d);
            x86enc_pkg::ACT_MOV_MR:   memf_b(1'b0, 8'h89, 1'b0, s, f, d);
            x86enc_pkg::ACT_ADD_RR:   rr_b(8'h01, s, f);
            x86enc_pkg::ACT_ADD_RI:   alu_b(3'd0, f, i32);
            x86enc_pkg::ACT_ADD_MR:   memf_b(1'b0, 8'h01, 1'b0, s, f, d);
            x86enc_pkg::ACT_SUB_RR:   rr_b(8'h29, s, f);
            x86enc_pkg::ACT_SUB_RI:   alu_b(3'd5, f, i32);
            x86enc_pkg::ACT_IMUL_RR:  two_b(8'hAF, f, s);
            x86enc_pkg::ACT_IMUL_RRI: begin
                rex_b(1'b1, f, s);
                if (in8(i32)) begin
                    emit(8'h6B); modrm_b(2'd3, f, s); emit(i8);
                end else begin
                    emit(8'h69); modrm_b(2'd3, f, s); emit32(i32);
                end
            end
            x86enc_pkg::ACT_AND_RR:   rr_b(8'h21, s, f);
            x86enc_pkg::ACT_AND_RI:   alu_b(3'd4, f, i32);
            x86enc_pkg::ACT_OR_RR:    rr_b(8'h09, s, f);
            x86enc_pkg::ACT_OR_RI:    alu_b(3'd1, f, i32);
            x86enc_pkg::ACT_XOR_RR:   rr_b(8'h31, s, f);
            x86enc_pkg::ACT_XOR_RI:   alu_b(3'd6, f, i32);
            x86enc_pkg::ACT_SHL_CL:   shcl_b(3'd4, f);
            x86enc_pkg::ACT_SHL_RI:   shi_b(3'd4, f, i8);
            x86enc_pkg::ACT_SAR_CL:   shcl_b(3'd7, f);
            x86enc_pkg::ACT_SAR_RI:   shi_b(3'd7, f, i8);
            x86enc_pkg::ACT_SHR_CL:   shcl_b(3'd5, f);
            x86enc_pkg::ACT_SHR_RI:   shi_b(3'd5, f, i8);
            x86enc_pkg::ACT_BTS_RR:   two_b(8'hAB, s, f);
            x86enc_pkg::ACT_BTS_RI:   bit_b(3'd5, f, i8);
            x86enc_pkg::ACT_BTR_RR:   two_b(8'hB3, s, f);
            x86enc_pkg::ACT_BTR_RI:   bit_b(3'd6, f, i8);
            x86enc_pkg::ACT_POPCNT: begin
                emit(x86enc_pkg::REP_PFX); two_b(8'hB8, f, s);
            end
            x86enc_pkg::ACT_LZCNT: begin
                emit(x86enc_pkg::REP_PFX); two_b(8'hBD, f, s);
            end
            x86enc_pkg::ACT_CMP_RR:   rr_b(8'h39, s, f);
            x86enc_pkg::ACT_CMP_RI:   alu_b(3'd7, f, i32);
            x86enc_pkg::ACT_TEST_RR:  rr_b(8'h85, s, f);
            x86enc_pkg::ACT_JMP:      jump_b(8'h00);
            x86enc_pkg::ACT_JE:       jump_b(8'h84);
            x86enc_pkg::ACT_JNE:      jump_b(8'h85);
            x86enc_pkg::ACT_JL:       jump_b(8'h8C);
            x86enc_pkg::ACT_JGE:      jump_b(8'h8D);
            x86enc_pkg::ACT_CALL: begin
                rex_b(1'b0, 4'd0, f); emit(8'hFF); modrm_b(2'd3, 4'd2, f);
            end
            x86enc_pkg::ACT_PUSH: begin
                if (f[3]) emit(8'h41);
                emit(8'h50 + {5'd0, f[2:0]});
            end
            x86enc_pkg::ACT_POP: begin
                if (f[3]) emit(8'h41);
                emit(8'h58 + {5'd0, f[2:0]});
            end
            x86enc_pkg::ACT_RET:          emit(8'hC3);
            x86enc_pkg::ACT_LOCK_CMPXCHG: memf_b(1'b1, 8'hB1, 1'b1, s, f, d);
            x86enc_pkg::ACT_XCHG_MR:      memf_b(1'b0, 8'h87, 1'b0, s, f, d);
            x86enc_pkg::ACT_LOCK_ADD:     memf_b(1'b1, 8'h01, 1'b0, s, f, d);
            x86enc_pkg::ACT_LOCK_AND:     memf_b(1'b1, 8'h21, 1'b0, s, f, d);
            x86enc_pkg::ACT_LOCK_OR:      memf_b(1'b1, 8'h09, 1'b0, s, f, d);
            x86enc_pkg::ACT_MFENCE: begin
                emit(x86enc_pkg::ESC_0F); emit(8'hAE); emit(8'hF0);
            end
            x86enc_pkg::ACT_CLFLUSH: begin
                rex_b(1'b0, 4'd0, f); emit(x86enc_pkg::ESC_0F); emit(8'hAE);
                mem_b(4'd7, f, d);
            end
            default: ;
        endcase
        for (int k = 0; k < buf_b.size(); k++) begin
            e.code   = buf_b[k];
            e.pos    = stream_offset + 32'(k);
            e.last   = (k == buf_b.size() - 1);
            e.pstart = (k == patch_at) && (lb < x86enc_pkg::LABEL_SLOTS);
            e.plabel = e.pstart ? lb : 6'd0;
            byte_queue.push_back(e);
        end
        stream_offset = stream_offset + 32'(buf_b.size());
    endfunction

    always @(posedge aclk) begin
        code_byte_t e;
        if (!aresetn) begin
            stream_offset = 0;
            byte_queue.delete();
            fail_count <= 0;
            bytes_seen <= 0;
        end else begin
            if (m_valid && m_ready) begin
                bytes_seen <= bytes_seen + 1;
                if (byte_queue.size() == 0) begin
                    $error("byte with none expected: %h at %0d", m_code_byte, m_byte_position);
                    fail_count <= fail_count + 1;
                end else begin
                    e = byte_queue.pop_front();
                    if (m_code_byte !== e.code || m_byte_position !== e.pos ||
                        m_last_byte !== e.last || m_patch_start !== e.pstart ||
                        m_patch_label !== e.plabel) begin
                        if (m_code_byte !== e.code)
                            $error("code_byte exp %h got %h", e.code, m_code_byte);
                        if (m_byte_position !== e.pos)
                            $error("byte_position exp %0d got %0d", e.pos, m_byte_position);
                        if (m_last_byte !== e.last)
                            $error("last_byte exp %b got %b", e.last, m_last_byte);
                        if (m_patch_start !== e.pstart)
                            $error("patch_start exp %b got %b", e.pstart, m_patch_start);
                        if (m_patch_label !== e.plabel)
                            $error("patch_label exp %0d got %0d", e.plabel, m_patch_label);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            if (s_valid && s_ready)
                predict_bytes(s_action, s_first_reg, s_second_reg, s_displacement,
                              s_immediate, s_jump_label);
        end
    end

endmodule

FILE: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives directed and random instruction requests into the byte encoder with
// random gaps and output stalls; the checker predicts and compares bytes.
// ----------------------------------------------------------------------------
module testbench;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [5:0]  s_action;
    logic [3:0]  s_first_reg;
    logic [3:0]  s_second_reg;
    logic [31:0] s_displacement;
    logic [63:0] s_immediate;
    logic [5:0]  s_jump_label;
    logic        m_valid;
    logic        m_ready;
    logic [7:0]  m_code_byte;
    logic [31:0] m_byte_position;
    logic        m_last_byte;
    logic        m_patch_start;
    logic [5:0]  m_patch_label;
    int          fail_count;
    int          pending;
    int          bytes_seen;
    int          requests_sent;
    logic        stall_burst;

    x86_64_instruction_byte_encoder uut (.*);

    encoder_checker chk (.*);

    initial begin
        aclk = 0;
        forever #4 aclk = ~aclk;
    end

    initial begin
        #3000000;
        $display("timeout");
        $display("== FAIL ==");
        $finish;
    end

    function automatic int gap_len();
        if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
        if ($urandom_range(0, 2) == 0) return $urandom_range(1, 3);
        return 0;
    endfunction

    // output stall: long runs of no stalling alternate with random stalling
    initial begin
        m_ready = 0;
        stall_burst = 0;
        forever begin
            @(posedge aclk);
            if ($urandom_range(0, 63) == 0) stall_burst <= ~stall_burst;
            if (stall_burst) m_ready <= 1'b1;
            else m_ready <= ($urandom_range(0, 9) != 0) ||
                            ($urandom_range(0, 29) == 0 ? 1'b0 : $urandom_range(0, 1));
        end
    end

    task automatic send_request(logic [5:0] a, logic [3:0] f, logic [3:0] s,
                                logic [31:0] d, logic [63:0] imm, logic [5:0] lb);
        s_valid        <= 1'b1;
        s_action       <= a;
        s_first_reg    <= f;
        s_second_reg   <= s;
        s_displacement <= d;
        s_immediate    <= imm;
        s_jump_label   <= lb;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        requests_sent++;
    endtask

    task automatic idle_gap(int n);
        s_valid <= 1'b0;
        repeat (n) @(posedge aclk);
    endtask

    function automatic logic [31:0] rand_disp();
        case ($urandom_range(0, 5))
            0: return 0;
            1: return $urandom_range(0, 255) - 128;
            2: return $urandom_range(0, 1) ? 32'd127 : 32'd128;
            3: return $urandom_range(0, 1) ? 32'hFFFF_FF80 : 32'hFFFF_FF7F;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [63:0] rand_imm();
        case ($urandom_range(0, 4))
            0: return {$urandom, 32'd0} | $urandom_range(0, 2);
            1: return {$urandom, $urandom_range(0, 255) - 128};
            2: return {$urandom, 32'h8000_0000};
            default: return {$urandom, $urandom};
        endcase
    endfunction

    initial begin
        int wait_cycles;
        aresetn = 0;
        s_valid = 0;
        s_action = 0;
        s_first_reg = 0;
        s_second_reg = 0;
        s_displacement = 0;
        s_immediate = 0;
        s_jump_label = 0;
        requests_sent = 0;
        repeat (6) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // directed: every form, base register corners, displacement and immediate edges
        for (int a = 0; a <= x86enc_pkg::ACT_CLFLUSH; a++)
            send_request(a[5:0], a[3:0], 4'(15 - a), rand_disp(), rand_imm(), a[5:0]);
        send_request(x86enc_pkg::ACT_MOV_RR, 4'd7, 4'd7, 0, 0, 0);
        send_request(x86enc_pkg::ACT_MOV_RM, 4'd15, 4'd12, 32'd0, 0, 0);
        send_request(x86enc_pkg::ACT_MOV_MR, 4'd13, 4'd8, 32'd0, 0, 0);
        send_request(x86enc_pkg::ACT_ADD_MR, 4'd4, 4'd0, 32'h8000_0000, 0, 0);
        send_request(x86enc_pkg::ACT_ADD_RI, 4'd8, 4'd0, 0, 64'hFFFF_FFFF_FFFF_FF80, 0);
        send_request(x86enc_pkg::ACT_SHL_RI, 4'd9, 4'd0, 0, 64'd1, 0);
        send_request(x86enc_pkg::ACT_MOV_RI64, 4'd15, 4'd0, 0, 64'hFFFF_FFFF_FFFF_FFFF, 0);
        send_request(x86enc_pkg::ACT_JE, 4'd0, 4'd0, 0, 0, 6'd63);
        send_request(6'd63, 4'd0, 4'd0, 0, 0, 0);
        send_request(x86enc_pkg::ACT_RESTART, 4'd0, 4'd0, 0, 0, 0);
        send_request(x86enc_pkg::ACT_RET, 4'd0, 4'd0, 0, 0, 0);

        // hold off until every expected byte has left
        s_valid <= 1'b0;
        while (pending != 0) @(posedge aclk);

        for (int n = 0; n < 390; n++) begin
            int r;
            logic [5:0] a;
            r = $urandom_range(0, 99);
            if (r < 2) a = x86enc_pkg::ACT_RESTART;
            else if (r < 4) a = 6'($urandom_range(50, 63));
            else a = 6'($urandom_range(0, x86enc_pkg::ACT_CLFLUSH));
            send_request(a, 4'($urandom), 4'($urandom), rand_disp(), rand_imm(),
                         6'($urandom));
            wait_cycles = gap_len();
            if (wait_cycles != 0) idle_gap(wait_cycles);
        end
        s_valid <= 1'b0;

        wait_cycles = 0;
        while (pending != 0 && wait_cycles < 100000) begin
            @(posedge aclk);
            wait_cycles++;
        end
        repeat (20) @(posedge aclk);
        $display("%0d requests sent, %0d code bytes checked, all forms and corners",
                 requests_sent, bytes_seen);
        if (fail_count == 0 && pending == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

FILE: sim.f
sv/x86enc_pkg.sv
sv/x86enc_front.sv
sv/x86enc_queue.sv
sv/x86enc_back.sv
sv/x86_64_instruction_byte_encoder.sv
tb/encoder_checker.sv
tb/testbench.sv
